// File: sv/cleh_pkg.sv
// Shared types and constants of the console line editor with history.
`timescale 1ns / 1ps
package cleh_pkg;

   localparam int LINE_AW = 8;                      // line buffer address bits
   localparam int HIST_AW = 7;                      // history slot bits
   localparam int HIST_DEPTH = 1 << HIST_AW;
   localparam int HIST_WORDS = HIST_DEPTH << LINE_AW;
   localparam logic [7:0] LINE_MAX = 8'd255;

   // request commands
   localparam logic [1:0] CMD_KEY = 2'd0;
   localparam logic [1:0] CMD_INT = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // key codes
   localparam logic [7:0] KEY_CTRL_A = 8'd1;
   localparam logic [7:0] KEY_CTRL_B = 8'd2;
   localparam logic [7:0] KEY_CTRL_D = 8'd4;
   localparam logic [7:0] KEY_CTRL_E = 8'd5;
   localparam logic [7:0] KEY_CTRL_F = 8'd6;
   localparam logic [7:0] KEY_BS = 8'd8;
   localparam logic [7:0] KEY_TAB = 8'd9;
   localparam logic [7:0] KEY_LF = 8'd10;
   localparam logic [7:0] KEY_CTRL_K = 8'd11;
   localparam logic [7:0] KEY_CR = 8'd13;
   localparam logic [7:0] KEY_CTRL_N = 8'd14;
   localparam logic [7:0] KEY_CTRL_P = 8'd16;
   localparam logic [7:0] KEY_ESC = 8'd27;
   localparam logic [7:0] KEY_SPACE = 8'd32;
   localparam logic [7:0] KEY_TILDE = 8'd126;
   localparam logic [7:0] KEY_DEL = 8'd127;
   localparam logic [7:0] KEY_BRACKET = 8'h5b;
   localparam logic [7:0] KEY_UP = 8'h41;
   localparam logic [7:0] KEY_DOWN = 8'h42;
   localparam logic [7:0] KEY_RIGHT = 8'h43;
   localparam logic [7:0] KEY_LEFT = 8'h44;

   typedef enum logic [2:0] {
      ST_QUIET    = 3'd0,
      ST_ECHO     = 3'd1,
      ST_REDRAW   = 3'd2,
      ST_BELL     = 3'd3,
      ST_DONE     = 3'd4,
      ST_EXIT     = 3'd5,
      ST_COMPLETE = 3'd6,
      ST_READ     = 3'd7
   } st_type;

   // byte mover operations
   typedef enum logic [2:0] {
      MV_READ   = 3'd0,   // read line byte at lo
      MV_HLEN   = 3'd1,   // read stored length of slot
      MV_INS    = 3'd2,   // open a gap at lo, shift up to hi, put key at lo
      MV_DEL    = 3'd3,   // close the gap at lo, shift down to hi
      MV_RECALL = 3'd4,   // copy hi bytes of slot into the line
      MV_COMMIT = 3'd5    // copy hi bytes of the line into slot, store length
   } mv_type;

   typedef struct packed {
      logic               start;
      mv_type             mode;
      logic [7:0]         lo;
      logic [7:0]         hi;
      logic [HIST_AW-1:0] slot;
      logic [7:0]         key;
   } dp_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [7:0] rdata;
   } dp_sts_type;

endpackage

// File: sv/cleh_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module cleh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cleh_datapath.sv
// Line buffer, history store and the byte mover that shifts and copies between them.
`timescale 1ns / 1ps
module cleh_datapath
   import cleh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   output dp_sts_type sts
);

   typedef enum logic [1:0] {M_IDLE, M_RD, M_WR} mph_type;

   mph_type            ph_ff, ph_in;
   mv_type             mode_ff, mode_in;
   logic [7:0]         lo_ff, lo_in, hi_ff, hi_in, key_ff, key_in, ptr_ff, ptr_in;
   logic [HIST_AW-1:0] slot_ff, slot_in;
   logic               done_ff, done_in;
   logic [7:0]         rdata_ff, rdata_in;

   logic                       line_we, hist_we, hlen_we;
   logic [LINE_AW-1:0]         line_wa, line_ra;
   logic [7:0]                 line_wd, line_q, hist_wd, hist_q, hlen_q;
   logic [HIST_AW+LINE_AW-1:0] hist_wa, hist_ra;

   cleh_ram #(.WIDTH(8), .DEPTH(1 << LINE_AW)) u_line (
      .clock, .wr_en(line_we), .wr_addr(line_wa), .wr_data(line_wd),
      .rd_addr(line_ra), .rd_data(line_q)
   );

   cleh_ram #(.WIDTH(8), .DEPTH(HIST_WORDS)) u_hist (
      .clock, .wr_en(hist_we), .wr_addr(hist_wa), .wr_data(hist_wd),
      .rd_addr(hist_ra), .rd_data(hist_q)
   );

   cleh_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hlen (
      .clock, .wr_en(hlen_we), .wr_addr(slot_ff), .wr_data(hi_ff),
      .rd_addr(slot_ff), .rd_data(hlen_q)
   );

   always_comb begin
      ph_in = ph_ff;
      mode_in = mode_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      key_in = key_ff;
      slot_in = slot_ff;
      ptr_in = ptr_ff;
      done_in = 1'b0;
      rdata_in = rdata_ff;
      line_we = 1'b0;
      line_wa = ptr_ff;
      line_wd = line_q;
      line_ra = ptr_ff;
      hist_we = 1'b0;
      hist_wa = {slot_ff, ptr_ff};
      hist_wd = line_q;
      hist_ra = {slot_ff, ptr_ff};
      hlen_we = 1'b0;
      unique case (ph_ff)
         M_IDLE: begin
            if (cmd.start) begin
               mode_in = cmd.mode;
               lo_in = cmd.lo;
               hi_in = cmd.hi;
               key_in = cmd.key;
               slot_in = cmd.slot;
               ptr_in = (cmd.mode == MV_INS) ? cmd.hi :
                        (cmd.mode == MV_DEL) ? cmd.lo : 8'd0;
               ph_in = M_RD;
            end
         end
         M_RD: begin
            ph_in = M_WR;
            unique case (mode_ff)
               MV_INS: begin
                  if (ptr_ff > lo_ff) begin
                     line_ra = ptr_ff - 8'd1;
                  end else begin
                     line_we = 1'b1;
                     line_wd = key_ff;
                     ph_in = M_IDLE;
                     done_in = 1'b1;
                  end
               end
               MV_DEL: begin
                  if (ptr_ff < hi_ff) begin
                     line_ra = ptr_ff + 8'd1;
                  end else begin
                     ph_in = M_IDLE;
                     done_in = 1'b1;
                  end
               end
               MV_RECALL: begin
                  if (ptr_ff >= hi_ff) begin
                     ph_in = M_IDLE;
                     done_in = 1'b1;
                  end
               end
               MV_COMMIT: begin
                  if (ptr_ff >= hi_ff) begin
                     hlen_we = 1'b1;
                     ph_in = M_IDLE;
                     done_in = 1'b1;
                  end
               end
               MV_READ: line_ra = lo_ff;
               MV_HLEN: ;
               default: ph_in = M_IDLE;
            endcase
         end
         M_WR: begin
            ph_in = M_RD;
            unique case (mode_ff)
               MV_INS: begin
                  line_we = 1'b1;
                  ptr_in = ptr_ff - 8'd1;
               end
               MV_DEL: begin
                  line_we = 1'b1;
                  ptr_in = ptr_ff + 8'd1;
               end
               MV_RECALL: begin
                  line_we = 1'b1;
                  line_wd = hist_q;
                  ptr_in = ptr_ff + 8'd1;
               end
               MV_COMMIT: begin
                  hist_we = 1'b1;
                  ptr_in = ptr_ff + 8'd1;
               end
               MV_READ: begin
                  rdata_in = line_q;
                  done_in = 1'b1;
                  ph_in = M_IDLE;
               end
               MV_HLEN: begin
                  rdata_in = hlen_q;
                  done_in = 1'b1;
                  ph_in = M_IDLE;
               end
               default: ph_in = M_IDLE;
            endcase
         end
         default: ph_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      key_ff <= key_in;
      slot_ff <= slot_in;
      ptr_ff <= ptr_in;
      rdata_ff <= rdata_in;
   end

   assign sts.busy = (ph_ff != M_IDLE);
   assign sts.done = done_ff;
   assign sts.rdata = rdata_ff;

endmodule

// File: sv/cleh_ctrl.sv
// Key decoder and sequencing state machine holding the editor's scalar state.
`timescale 1ns / 1ps
module cleh_ctrl
   import cleh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_key,
   input  logic [7:0]  req_index,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output st_type      rsp_status,
   output logic [7:0]  rsp_cursor,
   output logic [7:0]  rsp_length,
   output logic [7:0]  rsp_char,
   output dp_cmd_type  dp_cmd,
   input  dp_sts_type  dp_sts
);

   typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_HLEN, S_MOVE, S_READ, S_RESP} state_type;
   typedef enum logic [1:0] {PH_PLAIN, PH_ESC, PH_CSI} phase_type;
   typedef enum logic [2:0] {A_NONE, A_UP, A_DOWN, A_LEFT, A_RIGHT} act_type;

   state_type          state_ff, state_in;
   phase_type          ph_ff, ph_in, ph_e;
   logic [1:0]         cmd_ff, cmd_in;
   logic [7:0]         key_ff, key_in, idx_ff, idx_in;
   logic [7:0]         cur_ff, cur_in, len_ff, len_in, cur_e, len_e;
   logic [7:0]         br_ff, br_in, br_e, cnt_ff, cnt_in, nb;
   logic [HIST_AW-1:0] new_ff, new_in;
   logic               com_ff, com_in, fresh;
   st_type             st_ff, st_in;
   logic [7:0]         ch_ff, ch_in;
   dp_cmd_type         dpc_ff, dpc_in;
   act_type            act;

   always_comb begin
      state_in = state_ff;
      ph_in = ph_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      len_in = len_ff;
      br_in = br_ff;
      cnt_in = cnt_ff;
      new_in = new_ff;
      com_in = com_ff;
      st_in = st_ff;
      ch_in = ch_ff;
      dpc_in = dpc_ff;
      dpc_in.start = 1'b0;
      act = A_NONE;
      nb = 8'd0;
      // a keystroke or interrupt after Enter starts from a fresh line
      fresh = com_ff && (cmd_ff == CMD_KEY || cmd_ff == CMD_INT);
      cur_e = fresh ? 8'd0 : cur_ff;
      len_e = fresh ? 8'd0 : len_ff;
      ph_e = fresh ? PH_PLAIN : ph_ff;
      br_e = fresh ? 8'd0 : br_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_command;
               key_in = req_key;
               idx_in = req_index;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cur_in = cur_e;
            len_in = len_e;
            ph_in = ph_e;
            br_in = br_e;
            com_in = com_ff && !fresh;
            st_in = ST_QUIET;
            ch_in = 8'd0;
            state_in = S_RESP;
            unique case (cmd_ff)
               CMD_KEY: begin
                  if (ph_e == PH_ESC) begin
                     ph_in = (key_ff == KEY_BRACKET) ? PH_CSI : PH_PLAIN;
                  end else if (ph_e == PH_CSI) begin
                     ph_in = PH_PLAIN;
                     unique case (key_ff)
                        KEY_UP:    act = A_UP;
                        KEY_DOWN:  act = A_DOWN;
                        KEY_RIGHT: act = A_RIGHT;
                        KEY_LEFT:  act = A_LEFT;
                        default:   st_in = ST_BELL;
                     endcase
                  end else begin
                     st_in = ST_REDRAW;
                     unique case (key_ff)
                        KEY_CTRL_A: cur_in = 8'd0;
                        KEY_CTRL_E: cur_in = len_e;
                        KEY_CTRL_K: len_in = cur_e;
                        KEY_CTRL_B: act = A_LEFT;
                        KEY_CTRL_F: act = A_RIGHT;
                        KEY_CTRL_P: act = A_UP;
                        KEY_CTRL_N: act = A_DOWN;
                        KEY_TAB:    st_in = ST_COMPLETE;
                        KEY_ESC: begin
                           ph_in = PH_ESC;
                           st_in = ST_QUIET;
                        end
                        KEY_CTRL_D, KEY_DEL: begin
                           if (key_ff == KEY_CTRL_D && len_e == 8'd0) begin
                              st_in = ST_EXIT;
                           end else if (cur_e >= len_e) begin
                              st_in = ST_QUIET;
                           end else begin
                              dpc_in = '{1'b1, MV_DEL, cur_e, len_e - 8'd1, new_ff, key_ff};
                              len_in = len_e - 8'd1;
                              state_in = S_MOVE;
                           end
                        end
                        KEY_BS: begin
                           if (cur_e == 8'd0) begin
                              st_in = ST_BELL;
                           end else begin
                              dpc_in = '{1'b1, MV_DEL, cur_e - 8'd1, len_e - 8'd1,
                                         new_ff, key_ff};
                              cur_in = cur_e - 8'd1;
                              len_in = len_e - 8'd1;
                              state_in = S_MOVE;
                           end
                        end
                        KEY_LF, KEY_CR: begin
                           st_in = ST_DONE;
                           com_in = 1'b1;
                           if (len_e != 8'd0) begin
                              new_in = new_ff + 1'b1;
                              dpc_in = '{1'b1, MV_COMMIT, 8'd0, len_e,
                                         new_ff + 1'b1, key_ff};
                              if (cnt_ff < 8'(HIST_DEPTH)) begin
                                 cnt_in = cnt_ff + 8'd1;
                              end
                              state_in = S_MOVE;
                           end
                        end
                        default: begin
                           if (key_ff < KEY_SPACE || key_ff > KEY_TILDE ||
                               len_e >= LINE_MAX) begin
                              st_in = ST_BELL;
                           end else begin
                              dpc_in = '{1'b1, MV_INS, cur_e, len_e, new_ff, key_ff};
                              cur_in = cur_e + 8'd1;
                              len_in = len_e + 8'd1;
                              state_in = S_MOVE;
                              if (cur_e == len_e) begin
                                 st_in = ST_ECHO;
                                 ch_in = key_ff;
                              end
                           end
                        end
                     endcase
                  end
               end
               CMD_INT: begin
                  cur_in = 8'd0;
                  len_in = 8'd0;
                  st_in = ST_REDRAW;
               end
               CMD_READ: begin
                  st_in = ST_READ;
                  dpc_in = '{1'b1, MV_READ, idx_ff, 8'd0, new_ff, key_ff};
                  state_in = S_READ;
               end
               default: st_in = ST_QUIET;
            endcase
            unique case (act)
               A_UP: begin
                  if (br_e >= cnt_ff) begin
                     st_in = ST_BELL;
                  end else begin
                     st_in = ST_REDRAW;
                     br_in = br_e + 8'd1;
                     dpc_in = '{1'b1, MV_HLEN, 8'd0, 8'd0, new_ff - br_e[HIST_AW-1:0],
                                key_ff};
                     state_in = S_HLEN;
                  end
               end
               A_DOWN: begin
                  st_in = ST_REDRAW;
                  nb = (br_e != 8'd0) ? br_e - 8'd1 : 8'd0;
                  br_in = nb;
                  if (nb == 8'd0) begin
                     cur_in = 8'd0;
                     len_in = 8'd0;
                  end else begin
                     dpc_in = '{1'b1, MV_HLEN, 8'd0, 8'd0,
                                new_ff - (nb[HIST_AW-1:0] - 1'b1), key_ff};
                     state_in = S_HLEN;
                  end
               end
               A_LEFT: begin
                  if (cur_e == 8'd0) begin
                     st_in = ST_BELL;
                  end else begin
                     st_in = ST_REDRAW;
                     cur_in = cur_e - 8'd1;
                  end
               end
               A_RIGHT: begin
                  if (cur_e >= len_e) begin
                     st_in = ST_BELL;
                  end else begin
                     st_in = ST_REDRAW;
                     cur_in = cur_e + 8'd1;
                  end
               end
               default: ;
            endcase
         end
         S_HLEN: begin
            if (dp_sts.done) begin
               cur_in = dp_sts.rdata;
               len_in = dp_sts.rdata;
               dpc_in.start = 1'b1;
               dpc_in.mode = MV_RECALL;
               dpc_in.hi = dp_sts.rdata;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (dp_sts.done) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            if (dp_sts.done) begin
               ch_in = (idx_ff < len_ff) ? dp_sts.rdata : 8'd0;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff <= PH_PLAIN;
         cur_ff <= 8'd0;
         len_ff <= 8'd0;
         br_ff <= 8'd0;
         cnt_ff <= 8'd0;
         new_ff <= '0;
         com_ff <= 1'b0;
         dpc_ff.start <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         cur_ff <= cur_in;
         len_ff <= len_in;
         br_ff <= br_in;
         cnt_ff <= cnt_in;
         new_ff <= new_in;
         com_ff <= com_in;
         dpc_ff.start <= dpc_in.start;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      st_ff <= st_in;
      ch_ff <= ch_in;
      dpc_ff.mode <= dpc_in.mode;
      dpc_ff.lo <= dpc_in.lo;
      dpc_ff.hi <= dpc_in.hi;
      dpc_ff.slot <= dpc_in.slot;
      dpc_ff.key <= dpc_in.key;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_status = st_ff;
   assign rsp_cursor = cur_ff;
   assign rsp_length = len_ff;
   assign rsp_char = ch_ff;
   assign dp_cmd = dpc_ff;

endmodule

// File: sv/console_line_editor_history.sv
// Top level of the console line editor with history.
//
// Requests come in on req_*: tuser carries the command (keystroke, interrupt,
// read line byte) and tdata the key byte and the read index. Every request
// gives exactly one response on rsp_*: tuser carries the status code, tdata
// the cursor, the line length and the echoed or read character.
// One request is in flight at a time; req_tready is high only while idle.
// Plain edits and cursor moves are answered by the decoder alone; a buffer
// read, insert or delete, Enter on a non-empty line and a history recall
// wait for the byte mover, which moves one line byte at a time through the
// buffer RAM port in alternating read and write phases.
// The response is held until rsp_tready; no new request is taken meanwhile.
// Reset empties the line and the history ring; no clearing pass is needed.
`timescale 1ns / 1ps
module console_line_editor_history
   import cleh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] key, [15:8] index
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] cursor, [15:8] length, [23:16] char_out
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;
   st_type     status;
   logic [7:0] cursor, length, char_out;

   cleh_ctrl u_ctrl (
      .clock, .reset,
      .req_tvalid, .req_tready,
      .req_command(req_tuser), .req_key(req_tdata[7:0]), .req_index(req_tdata[15:8]),
      .rsp_tvalid, .rsp_tready,
      .rsp_status(status), .rsp_cursor(cursor), .rsp_length(length), .rsp_char(char_out),
      .dp_cmd, .dp_sts
   );

   cleh_datapath u_dp (
      .clock, .reset, .cmd(dp_cmd), .sts(dp_sts)
   );

   assign rsp_tdata = {char_out, length, cursor};
   assign rsp_tuser = status;

   a_busy_not_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !dp_sts.busy)
      else $error("byte mover busy while idle");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while a response waits");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.start |=> dp_sts.busy)
      else $error("mover did not start");

endmodule

// File: tb/console_line_editor_history_test.sv
// Testbench for the console line editor with history: directed and random keystrokes.
`timescale 1ns / 1ps
module console_line_editor_history_test;
   import cleh_pkg::*;

   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam int ESC_NONE = 0;
   localparam int ESC_SEEN = 1;
   localparam int ESC_CSI = 2;

   typedef struct {
      st_type     st;
      logic [7:0] cur;
      logic [7:0] len;
      logic [7:0] ch;
   } editor_rsp_type;

   // Keeps its own copy of the editor state and checks responses in order.
   class editor_scoreboard;
      bit [7:0]       line_buf [0:255];
      bit [7:0]       hist_buf [0:127][0:254];
      int             hist_len [0:127];
      int             cur, len, phase, newest, count, browse;
      bit             committed;
      int             errors;
      editor_rsp_type pending [$];

      function new();
         foreach (hist_len[i]) hist_len[i] = 0;
         newest = 0;
         count = 0;
         errors = 0;
         fresh();
      endfunction

      function void wipe();
         foreach (line_buf[i]) line_buf[i] = 0;
         cur = 0;
         len = 0;
      endfunction

      function void fresh();
         wipe();
         phase = ESC_NONE;
         browse = 0;
         committed = 0;
      endfunction

      function void load(int age);
         int slot;
         slot = (newest + 128 - age % 128) % 128;
         wipe();
         for (int i = 0; i < hist_len[slot]; i++) line_buf[i] = hist_buf[slot][i];
         len = hist_len[slot];
         cur = len;
      endfunction

      function st_type older();
         if (browse >= count) return ST_BELL;
         browse++;
         load(browse - 1);
         return ST_REDRAW;
      endfunction

      function st_type newer();
         if (browse > 0) browse--;
         if (browse == 0) wipe();
         else load(browse - 1);
         return ST_REDRAW;
      endfunction

      function st_type left();
         if (cur == 0) return ST_BELL;
         cur--;
         return ST_REDRAW;
      endfunction

      function st_type right();
         if (cur >= len) return ST_BELL;
         cur++;
         return ST_REDRAW;
      endfunction

      function st_type erase();
         if (cur >= len) return ST_QUIET;
         for (int i = cur; i < len - 1; i++) line_buf[i] = line_buf[i + 1];
         len--;
         line_buf[len] = 0;
         return ST_REDRAW;
      endfunction

      function st_type plain(logic [7:0] c, ref logic [7:0] echo);
         st_type s;
         case (c)
            KEY_CTRL_A: begin cur = 0; return ST_REDRAW; end
            KEY_CTRL_E: begin cur = len; return ST_REDRAW; end
            KEY_CTRL_K: begin
               for (int i = cur; i < len; i++) line_buf[i] = 0;
               len = cur;
               return ST_REDRAW;
            end
            KEY_CTRL_B: return left();
            KEY_CTRL_F: return right();
            KEY_CTRL_P: return older();
            KEY_CTRL_N: return newer();
            KEY_TAB: return ST_COMPLETE;
            KEY_ESC: begin phase = ESC_SEEN; return ST_QUIET; end
            KEY_CTRL_D: return (len == 0) ? ST_EXIT : erase();
            KEY_DEL: return erase();
            KEY_BS: begin
               if (cur == 0) return ST_BELL;
               cur--;
               s = erase();
               return ST_REDRAW;
            end
            KEY_LF, KEY_CR: begin
               if (len > 0) begin
                  newest = (newest + 1) % 128;
                  for (int i = 0; i < len; i++) hist_buf[newest][i] = line_buf[i];
                  hist_len[newest] = len;
                  if (count < 128) count++;
               end
               committed = 1;
               return ST_DONE;
            end
            default: ;
         endcase
         if (c < KEY_SPACE || c > KEY_TILDE || len >= 255) return ST_BELL;
         if (cur < len) begin
            for (int i = len; i > cur; i--) line_buf[i] = line_buf[i - 1];
            line_buf[cur] = c;
            cur++;
            len++;
            return ST_REDRAW;
         end
         line_buf[cur] = c;
         cur++;
         len++;
         echo = c;
         return ST_ECHO;
      endfunction

      // Accepted request: work out the response it must give.
      function void note(logic [1:0] cmd, logic [7:0] key, logic [7:0] idx);
         editor_rsp_type r;
         r.ch = 0;
         r.st = ST_QUIET;
         if (cmd == CMD_KEY) begin
            if (committed) fresh();
            if (phase == ESC_SEEN) begin
               phase = (key == KEY_BRACKET) ? ESC_CSI : ESC_NONE;
            end else if (phase == ESC_CSI) begin
               phase = ESC_NONE;
               case (key)
                  KEY_UP: r.st = older();
                  KEY_DOWN: r.st = newer();
                  KEY_RIGHT: r.st = right();
                  KEY_LEFT: r.st = left();
                  default: r.st = ST_BELL;
               endcase
            end else begin
               r.st = plain(key, r.ch);
            end
         end else if (cmd == CMD_INT) begin
            if (committed) fresh();
            wipe();
            r.st = ST_REDRAW;
         end else if (cmd == CMD_READ) begin
            r.st = ST_READ;
            if (idx < len) r.ch = line_buf[idx];
         end
         r.cur = cur[7:0];
         r.len = len[7:0];
         pending.push_back(r);
      endfunction

      function void check(logic [2:0] st, logic [7:0] c, logic [7:0] l, logic [7:0] ch);
         editor_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response status %0d", $time, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (st !== e.st || c !== e.cur || l !== e.len || ch !== e.ch) begin
            $display("%0t: mismatch exp st=%0d cur=%0d len=%0d ch=%0d",
                     $time, e.st, e.cur, e.len, e.ch,
                     ", got st=%0d cur=%0d len=%0d ch=%0d", st, c, l, ch);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   editor_scoreboard sb;
   int send_idle_pct;
   int stall_pct;
   int sent_n;

   console_line_editor_history dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   // response side: random backpressure, checks at the rising edge
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && sb != null && rsp_tvalid && rsp_tready)
         sb.check(rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]);
   end

   task automatic send(logic [1:0] cmd, logic [7:0] key, logic [7:0] idx = 8'd0);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {idx, key};
      do @(posedge clock); while (!req_tready);
      sb.note(cmd, key, idx);
      sent_n++;
   endtask

   task automatic key_in(logic [7:0] k);
      send(CMD_KEY, k);
   endtask

   task automatic esc_seq(logic [7:0] k);
      key_in(KEY_ESC);
      key_in(KEY_BRACKET);
      key_in(k);
   endtask

   task automatic random_burst();
      int pick, n;
      logic [7:0] ctl [12];
      ctl = '{KEY_CTRL_A, KEY_CTRL_E, KEY_CTRL_K, KEY_CTRL_B, KEY_CTRL_F, KEY_CTRL_P,
              KEY_CTRL_N, KEY_CTRL_D, KEY_DEL, KEY_BS, KEY_TAB, KEY_ESC};
      pick = $urandom_range(99);
      if (pick < 45) begin
         // short line, mostly followed by enter, feeds the history ring
         n = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         repeat (n) key_in(8'($urandom_range(KEY_SPACE, KEY_TILDE)));
         if ($urandom_range(3) != 0) key_in($urandom_range(1) ? KEY_CR : KEY_LF);
      end else if (pick < 65) begin
         repeat ($urandom_range(1, 4)) key_in(ctl[$urandom_range(11)]);
      end else if (pick < 78) begin
         case ($urandom_range(5))
            0: esc_seq(KEY_UP);
            1: esc_seq(KEY_DOWN);
            2: esc_seq(KEY_RIGHT);
            3: esc_seq(KEY_LEFT);
            4: esc_seq(8'($urandom_range(255)));
            default: begin key_in(KEY_ESC); key_in(8'($urandom_range(255))); end
         endcase
      end else if (pick < 88) begin
         send(CMD_READ, 8'($urandom_range(255)),
              $urandom_range(1) ? 8'($urandom_range(sb.len)) : 8'($urandom_range(255)));
      end else if (pick < 92) begin
         send(CMD_INT, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 94) begin
         send(CMD_NOP, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
         key_in(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int start_n;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = CMD_KEY;
      send_idle_pct = 0;
      stall_pct = 0;
      sent_n = 0;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // edges and every key kind
      key_in(KEY_CTRL_D);
      key_in(KEY_BS);
      key_in(KEY_CTRL_B);
      key_in(KEY_CTRL_P);
      key_in(KEY_CTRL_N);
      key_in(KEY_TAB);
      key_in(KEY_SPACE);
      key_in(KEY_TILDE);
      key_in(KEY_DEL);
      key_in(KEY_CTRL_A);
      key_in("x");
      key_in(KEY_CTRL_F);
      key_in(KEY_DEL);
      key_in(KEY_CTRL_E);
      key_in(KEY_CTRL_F);
      key_in(KEY_CTRL_D);
      key_in(8'd0);
      key_in(8'd255);
      send(CMD_READ, 8'd0, 8'd0);
      send(CMD_READ, 8'd0, 8'd255);
      key_in(KEY_ESC);
      key_in("q");
      esc_seq("Z");
      key_in(KEY_CR);
      send(CMD_READ, 8'd0, 8'd1);
      esc_seq(KEY_UP);
      key_in(KEY_CTRL_A);
      key_in(KEY_CTRL_K);
      send(CMD_INT, 8'd0);
      send(CMD_NOP, 8'hff, 8'hff);
      key_in(KEY_LF);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin send_idle_pct = 46; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 46; end
            3: begin send_idle_pct = 33; stall_pct = 33; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         start_n = sent_n;
         // one run to the full line, bell included
         if (ph == 2) begin
            repeat (257) key_in(8'($urandom_range(KEY_SPACE, KEY_TILDE)));
            key_in(KEY_CTRL_A);
            key_in("y");
            key_in(KEY_CR);
            start_n = sent_n;
         end
         while (sent_n - start_n < 92) random_burst();
      end

      @(negedge clock);
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
